/* hdl/abrb_pkg.sv */
// abrb_pkg: shared types and constants of the audio block ring buffer
// no dependencies; used by every module of the block and by its checker
package abrb_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int RC_W         = 7;
    localparam int BLK_LEN_W    = 9;
    localparam int BLK_CNT_W    = 4;
    localparam int FILL_W       = 4;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    typedef enum logic
    {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    typedef enum logic
    {
        REG_BLK_LEN = 1'b0,
        REG_BLK_CNT = 1'b1
    } reg_idx_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } ctrl_state_t;

    typedef struct packed
    {
        action_t                     action;
        logic signed [SAMPLE_W-1:0]  sample_in;
        logic [RC_W-1:0]             read_count;
    } in_item_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0]  sample_out;
        logic                        last;
        logic                        underrun;
        logic                        dropped;
        logic [FILL_W-1:0]           blocks_full;
    } out_item_t;

    // commands from the controller to the datapath
    typedef struct packed
    {
        logic write;
        logic read_step;
        logic last;
    } dp_cmd_t;

    // bits needed to index n entries
    function automatic int idx_width(input int n);
        int w;
        w = 0;
        while ((1 << w) < n)
        begin
            w = w + 1;
        end
        return w;
    endfunction

endpackage

/* hdl/abrb_regs.sv */
// abrb_regs: apb configuration registers (block length, block count) with clamping
// depends on abrb_pkg; a register write also flushes the ring pointers
module abrb_regs #(
    parameter int BLOCKS   = 8,
    parameter int ATOM_MAX = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [abrb_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [abrb_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [abrb_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    output logic [abrb_pkg::BLK_LEN_W-1:0]        blk_len,
    output logic [abrb_pkg::BLK_CNT_W-1:0]        blk_cnt,
    output logic                                  flush
);
    import abrb_pkg::*;

    localparam logic [BLK_LEN_W-1:0] SIZE_RST =
        (ATOM_MAX < 256) ? BLK_LEN_W'(ATOM_MAX) : BLK_LEN_W'(256);
    localparam logic [BLK_CNT_W-1:0] COUNT_RST =
        (BLOCKS < 8) ? BLK_CNT_W'(BLOCKS) : BLK_CNT_W'(8);

    logic [BLK_LEN_W-1:0] blk_len_reg, blk_len_next, size_wr;
    logic [BLK_CNT_W-1:0] blk_cnt_reg, blk_cnt_next, count_wr;
    logic                 wr_en;
    reg_idx_t             idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign flush  = wr_en;

    always_comb
    begin
        size_wr = pwdata[BLK_LEN_W-1:0];
        if (size_wr == '0)
        begin
            size_wr = BLK_LEN_W'(1);
        end
        else if (32'(size_wr) > ATOM_MAX)
        begin
            size_wr = BLK_LEN_W'(ATOM_MAX);
        end

        count_wr = pwdata[BLK_CNT_W-1:0];
        if (count_wr < BLK_CNT_W'(2))
        begin
            count_wr = BLK_CNT_W'(2);
        end
        else if (32'(count_wr) > BLOCKS)
        begin
            count_wr = BLK_CNT_W'(BLOCKS);
        end

        blk_len_next = blk_len_reg;
        blk_cnt_next = blk_cnt_reg;
        if (wr_en)
        begin
            case (idx)
                REG_BLK_LEN: blk_len_next = size_wr;
                REG_BLK_CNT: blk_cnt_next = count_wr;
                default:     blk_len_next = blk_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_len_reg <= SIZE_RST;
            blk_cnt_reg <= COUNT_RST;
        end
        else
        begin
            blk_len_reg <= blk_len_next;
            blk_cnt_reg <= blk_cnt_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_BLK_LEN: prdata = APB_DATA_W'(blk_len_reg);
            REG_BLK_CNT: prdata = APB_DATA_W'(blk_cnt_reg);
            default:     prdata = '0;
        endcase
    end

    assign blk_len = blk_len_reg;
    assign blk_cnt = blk_cnt_reg;

endmodule

/* hdl/abrb_ctrl.sv */
// abrb_ctrl: controller state machine, decodes items and sequences read bursts
// depends on abrb_pkg; drives dp_cmd_t commands into abrb_dp
module abrb_ctrl #(
    parameter int MAX_READ = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  abrb_pkg::in_item_t item,
    output logic               busy,
    output abrb_pkg::dp_cmd_t  cmd
);
    import abrb_pkg::*;

    ctrl_state_t     state_reg, state_next;
    logic [RC_W-1:0] remain_reg, remain_next, count_sat;

    assign count_sat = (32'(item.read_count) > MAX_READ) ? RC_W'(MAX_READ) : item.read_count;

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        cmd         = '0;
        busy        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.action == ACT_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else if (count_sat != '0)
                    begin
                        remain_next = count_sat;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                busy          = 1'b1;
                cmd.read_step = 1'b1;
                cmd.last      = (remain_reg == RC_W'(1));
                remain_next   = remain_reg - RC_W'(1);
                if (remain_reg == RC_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

endmodule

/* hdl/abrb_dp.sv */
// abrb_dp: datapath with the sample memory, ring pointers, fill count, result register
// depends on abrb_pkg; steered by abrb_ctrl commands and abrb_regs settings
module abrb_dp #(
    parameter int BLOCKS   = 8,
    parameter int ATOM_MAX = 256
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  abrb_pkg::dp_cmd_t                         cmd,
    input  logic signed [abrb_pkg::SAMPLE_W-1:0]      sample_in,
    input  logic                                      flush,
    input  logic [abrb_pkg::BLK_LEN_W-1:0]            blk_len,
    input  logic [abrb_pkg::BLK_CNT_W-1:0]            blk_cnt,
    output abrb_pkg::out_item_t                       result,
    output logic                                      result_valid
);
    import abrb_pkg::*;

    localparam int DEPTH  = BLOCKS * ATOM_MAX;
    localparam int AW     = idx_width(DEPTH);
    localparam int BW     = idx_width(BLOCKS);
    localparam int OW_RAW = idx_width(ATOM_MAX);
    localparam int OW     = (OW_RAW < 1) ? 1 : OW_RAW;
    localparam int CW     = (OW + 1 > BLK_LEN_W) ? OW + 1 : BLK_LEN_W;
    localparam int BCW    = (BW + 1 > BLK_CNT_W) ? BW + 1 : BLK_CNT_W;

    logic signed [SAMPLE_W-1:0] sample_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    logic [BW-1:0]     wr_blk_reg, wr_blk_next, rd_blk_reg, rd_blk_next;
    logic [AW-1:0]     wr_base_reg, wr_base_next, rd_base_reg, rd_base_next;
    logic [OW-1:0]     wr_off_reg, wr_off_next, rd_off_reg, rd_off_next;
    logic [FILL_W-1:0] filled_reg, filled_next;

    logic          full, wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          wr_off_wrap, wr_blk_wrap, rd_off_wrap, rd_blk_wrap;

    logic              res_valid_reg;
    logic              res_last_reg, res_underrun_reg, res_dropped_reg, res_mem_reg;
    logic [FILL_W-1:0] res_blocks_reg;

    assign full  = filled_reg >= FILL_W'(blk_cnt);
    assign wr_en = cmd.write && !full;
    assign rd_en = cmd.read_step && (filled_reg != '0);

    assign wr_addr = wr_base_reg + AW'(wr_off_reg);
    assign rd_addr = rd_base_reg + AW'(rd_off_reg);

    assign wr_off_wrap = (CW'(wr_off_reg) + CW'(1)) >= CW'(blk_len);
    assign rd_off_wrap = (CW'(rd_off_reg) + CW'(1)) >= CW'(blk_len);
    assign wr_blk_wrap = (BCW'(wr_blk_reg) + BCW'(1)) >= BCW'(blk_cnt);
    assign rd_blk_wrap = (BCW'(rd_blk_reg) + BCW'(1)) >= BCW'(blk_cnt);

    always_comb
    begin
        wr_blk_next  = wr_blk_reg;
        wr_base_next = wr_base_reg;
        wr_off_next  = wr_off_reg;
        rd_blk_next  = rd_blk_reg;
        rd_base_next = rd_base_reg;
        rd_off_next  = rd_off_reg;
        filled_next  = filled_reg;
        if (flush)
        begin
            wr_blk_next  = '0;
            wr_base_next = '0;
            wr_off_next  = '0;
            rd_blk_next  = '0;
            rd_base_next = '0;
            rd_off_next  = '0;
            filled_next  = '0;
        end
        else if (wr_en)
        begin
            if (wr_off_wrap)
            begin
                wr_off_next = '0;
                filled_next = filled_reg + FILL_W'(1);
                if (wr_blk_wrap)
                begin
                    wr_blk_next  = '0;
                    wr_base_next = '0;
                end
                else
                begin
                    wr_blk_next  = wr_blk_reg + BW'(1);
                    wr_base_next = wr_base_reg + AW'(ATOM_MAX);
                end
            end
            else
            begin
                wr_off_next = wr_off_reg + OW'(1);
            end
        end
        else if (rd_en)
        begin
            if (rd_off_wrap)
            begin
                rd_off_next = '0;
                filled_next = filled_reg - FILL_W'(1);
                if (rd_blk_wrap)
                begin
                    rd_blk_next  = '0;
                    rd_base_next = '0;
                end
                else
                begin
                    rd_blk_next  = rd_blk_reg + BW'(1);
                    rd_base_next = rd_base_reg + AW'(ATOM_MAX);
                end
            end
            else
            begin
                rd_off_next = rd_off_reg + OW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_blk_reg    <= '0;
            wr_base_reg   <= '0;
            wr_off_reg    <= '0;
            rd_blk_reg    <= '0;
            rd_base_reg   <= '0;
            rd_off_reg    <= '0;
            filled_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            wr_blk_reg    <= wr_blk_next;
            wr_base_reg   <= wr_base_next;
            wr_off_reg    <= wr_off_next;
            rd_blk_reg    <= rd_blk_next;
            rd_base_reg   <= rd_base_next;
            rd_off_reg    <= rd_off_next;
            filled_reg    <= filled_next;
            res_valid_reg <= cmd.write || cmd.read_step;
        end
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sample_mem[wr_addr] <= sample_in;
        end
        if (rd_en)
        begin
            rdata_reg <= sample_mem[rd_addr];
        end
    end

    // result payload, lines up with the registered memory read
    always_ff @(posedge clk)
    begin
        res_last_reg     <= cmd.write || cmd.last;
        res_underrun_reg <= cmd.read_step && !rd_en;
        res_dropped_reg  <= cmd.write && full;
        res_mem_reg      <= rd_en;
        res_blocks_reg   <= filled_next;
    end

    assign result_valid       = res_valid_reg;
    assign result.sample_out  = res_mem_reg ? rdata_reg : '0;
    assign result.last        = res_last_reg;
    assign result.underrun    = res_underrun_reg;
    assign result.dropped     = res_dropped_reg;
    assign result.blocks_full = res_blocks_reg;

endmodule

/* hdl/audio_block_ring_buffer.sv */
// audio_block_ring_buffer: top level, ring of sample blocks with zero-fill on underrun
// depends on abrb_pkg, abrb_regs, abrb_ctrl, abrb_dp
//
//   channel   | ports                                   | transaction
//   ----------+-----------------------------------------+------------------------------
//   command   | start, busy, item                       | start high while busy low
//   result    | result_valid, result                    | result_valid marks each result, no stall
//   config    | psel penable pwrite paddr pwdata prdata | apb write, pready tied high
//
// a write is decoded in the idle state; its result shows in the next cycle
// a read of n samples (n clamped to MAX_READ) is decoded in the idle state, then reads
// one sample per cycle through the single read port of the sample memory
// results show in the cycle after their memory read and cannot be stalled
// reset clears pointers and fill count; sample memory is not cleared
module audio_block_ring_buffer #(
    parameter int BLOCKS   = 8,
    parameter int ATOM_MAX = 256,
    parameter int MAX_READ = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  abrb_pkg::in_item_t               item,
    output logic                             result_valid,
    output abrb_pkg::out_item_t              result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [abrb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [abrb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [abrb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import abrb_pkg::*;

    logic [BLK_LEN_W-1:0] blk_len;
    logic [BLK_CNT_W-1:0] blk_cnt;
    logic                 flush;
    dp_cmd_t              cmd;

    abrb_regs #(
        .BLOCKS   (BLOCKS),
        .ATOM_MAX (ATOM_MAX)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .blk_len (blk_len),
        .blk_cnt (blk_cnt),
        .flush   (flush)
    );

    abrb_ctrl #(
        .MAX_READ (MAX_READ)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .cmd   (cmd)
    );

    abrb_dp #(
        .BLOCKS   (BLOCKS),
        .ATOM_MAX (ATOM_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample_in    (item.sample_in),
        .flush        (flush),
        .blk_len      (blk_len),
        .blk_cnt      (blk_cnt),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

/* hdl/abrb_checker.sv */
// abrb_checker: port-level assertions on the ring buffer top level
// depends on abrb_pkg; attached to audio_block_ring_buffer by the bind below
module abrb_checker #(
    parameter int BLOCKS = 8
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input abrb_pkg::in_item_t  item,
    input logic                result_valid,
    input abrb_pkg::out_item_t result
);
    import abrb_pkg::*;

    // a write transaction gives exactly one result, in the next cycle
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.action == ACT_WRITE |=> result_valid && result.last)
        else $error("write transaction without single result");

    // a read of nonzero length holds off further commands
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.action == ACT_READ && item.read_count != '0 |=> busy)
        else $error("read transaction did not raise busy");

    // padded and refused results carry no sample
    a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.underrun || result.dropped) |-> result.sample_out == '0)
        else $error("padded or dropped result carries data");

    // dropped is only for writes, which end their transaction at once
    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped |-> result.last && !result.underrun)
        else $error("dropped flag on a read result");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> 32'(result.blocks_full) <= BLOCKS)
        else $error("block count beyond ring size");

endmodule

bind audio_block_ring_buffer abrb_checker #(
    .BLOCKS (BLOCKS)
) u_abrb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);

/* tb/sv/audio_block_ring_buffer_tb.sv */
`timescale 1ns / 100ps
// audio_block_ring_buffer_tb: self-checking bench for the audio block ring buffer
// holds its own model of the block ring and checks every result transaction against it
// depends on abrb_pkg and audio_block_ring_buffer
module audio_block_ring_buffer_tb;

    import abrb_pkg::*;

    localparam int RING_BLOCKS  = 8;
    localparam int RING_ATOM    = 256;
    localparam int RING_READ    = 64;
    localparam int TAIL_CYCLES  = 80;
    localparam int REPORT_LIMIT = 10;

    class ring_scoreboard;
        logic [SAMPLE_W-1:0] sample_mem [0:RING_BLOCKS*RING_ATOM-1];
        int unsigned         blk_size;
        int unsigned         blk_count;
        int unsigned         wr_blk;
        int unsigned         wr_off;
        int unsigned         rd_blk;
        int unsigned         rd_off;
        int unsigned         full_blocks;
        out_item_t           pending [$];
        int unsigned         faults;

        function void flush();
            wr_blk      = 0;
            wr_off      = 0;
            rd_blk      = 0;
            rd_off      = 0;
            full_blocks = 0;
        endfunction

        function void reset_state();
            blk_size  = RING_ATOM;
            blk_count = RING_BLOCKS;
            faults    = 0;
            pending.delete();
            flush();
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
            int unsigned v;
            case (idx)
                REG_BLK_LEN:
                begin
                    v = value[BLK_LEN_W-1:0];
                    if (v < 1)
                        v = 1;
                    if (v > RING_ATOM)
                        v = RING_ATOM;
                    blk_size = v;
                end
                REG_BLK_CNT:
                begin
                    v = value[BLK_CNT_W-1:0];
                    if (v < 2)
                        v = 2;
                    if (v > RING_BLOCKS)
                        v = RING_BLOCKS;
                    blk_count = v;
                end
                default:
                    v = 0;
            endcase
            flush();
        endfunction

        // works out the results of one accepted command transaction
        function void note_item(in_item_t it);
            out_item_t   exp;
            int unsigned n;
            if (it.action == ACT_WRITE)
            begin
                exp      = '0;
                exp.last = 1'b1;
                if (full_blocks >= blk_count)
                    exp.dropped = 1'b1;
                else
                begin
                    sample_mem[wr_blk * RING_ATOM + wr_off] = it.sample_in;
                    wr_off++;
                    if (wr_off >= blk_size)
                    begin
                        wr_off = 0;
                        wr_blk++;
                        if (wr_blk >= blk_count)
                            wr_blk = 0;
                        full_blocks++;
                    end
                end
                exp.blocks_full = FILL_W'(full_blocks);
                pending.push_back(exp);
            end
            else
            begin
                n = it.read_count;
                if (n > RING_READ)
                    n = RING_READ;
                for (int unsigned k = 0; k < n; k++)
                begin
                    exp      = '0;
                    exp.last = (k + 1 == n);
                    if (full_blocks > 0)
                    begin
                        exp.sample_out = sample_mem[rd_blk * RING_ATOM + rd_off];
                        rd_off++;
                        if (rd_off >= blk_size)
                        begin
                            rd_off = 0;
                            rd_blk++;
                            if (rd_blk >= blk_count)
                                rd_blk = 0;
                            full_blocks--;
                        end
                    end
                    else
                        exp.underrun = 1'b1;
                    exp.blocks_full = FILL_W'(full_blocks);
                    pending.push_back(exp);
                end
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (pending.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("%0t: unexpected result sample=%0d last=%b und=%b drop=%b full=%0d",
                             $realtime, got.sample_out, got.last, got.underrun,
                             got.dropped, got.blocks_full);
                return;
            end
            exp = pending.pop_front();
            if (got.sample_out !== exp.sample_out || got.last !== exp.last ||
                got.underrun !== exp.underrun || got.dropped !== exp.dropped ||
                got.blocks_full !== exp.blocks_full)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display({"%0t: mismatch exp sample=%0d last=%b und=%b drop=%b full=%0d",
                              " | got sample=%0d last=%b und=%b drop=%b full=%0d"},
                             $realtime, exp.sample_out, exp.last, exp.underrun,
                             exp.dropped, exp.blocks_full, got.sample_out, got.last,
                             got.underrun, got.dropped, got.blocks_full);
            end
        endfunction
    endclass

    logic                    clk     = 1'b0;
    logic                    rst_n   = 1'b0;
    logic                    start   = 1'b0;
    logic                    busy;
    in_item_t                item    = '0;
    logic                    result_valid;
    out_item_t               result;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr   = '0;
    logic [APB_DATA_W-1:0]   pwdata  = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    ring_scoreboard sb;

    audio_block_ring_buffer #(
        .BLOCKS   (RING_BLOCKS),
        .ATOM_MAX (RING_ATOM),
        .MAX_READ (RING_READ)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    function automatic in_item_t make_item(action_t act, int sample, int cnt);
        in_item_t it;
        it.action     = act;
        it.sample_in  = sample[SAMPLE_W-1:0];
        it.read_count = cnt[RC_W-1:0];
        return it;
    endfunction

    // writes dominate so blocks fill; most reads ask for 1 to 2 * size + 2 samples, capped at RING_READ
    function automatic in_item_t random_item(int unsigned size, int write_pct);
        in_item_t    it;
        int unsigned span;
        it.sample_in  = SAMPLE_W'($urandom_range(0, 65535));
        it.read_count = RC_W'($urandom_range(0, 127));
        it.action     = ACT_WRITE;
        if ($urandom_range(0, 99) >= write_pct)
        begin
            it.action = ACT_READ;
            if ($urandom_range(0, 99) < 85)
            begin
                span = 2 * size + 2;
                if (span > RING_READ)
                    span = RING_READ;
                it.read_count = RC_W'($urandom_range(1, span));
            end
        end
        return it;
    endfunction

    // start stays high across back-to-back transactions
    task automatic send_item(in_item_t it);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic sender_gap(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < pct)
                @(posedge clk);
        end
    endtask

    // read count zero leaves no result behind, so also wait past the last pending result and until busy is low
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup_ring(int unsigned size_val, int unsigned count_val);
        drain();
        write_reg(REG_BLK_LEN, size_val);
        write_reg(REG_BLK_CNT, count_val);
    endtask

    task automatic random_phase(int unsigned size_val, int unsigned count_val, int pct,
                                int n_items, bit pause_mid);
        setup_ring(size_val, count_val);
        for (int i = 0; i < n_items; i++)
        begin
            if (pause_mid && i == n_items / 2)
                drain();
            else
                sender_gap(pct);
            send_item(random_item(sb.blk_size, 65));
        end
    endtask

    int unsigned phase_size  [6] = '{3, 1, 5, 2, 7, 4};
    int unsigned phase_count [6] = '{4, 0, 8, 3, 5, 15};
    int          phase_idle  [6] = '{0, 77, 7, 0, 77, 7};

    initial
    begin
        sb = new();
        sb.reset_state();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default ring: nothing complete yet, so reads pad with zeros
        send_item(make_item(ACT_WRITE, 32767, 0));
        send_item(make_item(ACT_WRITE, -32768, 127));
        send_item(make_item(ACT_READ, 0, 2));
        send_item(make_item(ACT_READ, -1, 0));

        // size 0 taken as 1, count 1 taken as 2: fill, overflow, drain past empty
        setup_ring(0, 1);
        send_item(make_item(ACT_WRITE, -32768, 0));
        send_item(make_item(ACT_WRITE, 32767, 0));
        send_item(make_item(ACT_WRITE, 16'h1234, 0));
        send_item(make_item(ACT_READ, 0, 3));
        send_item(make_item(ACT_WRITE, 5, 0));
        send_item(make_item(ACT_READ, 0, 127));
        send_item(make_item(ACT_READ, 0, 0));
        send_item(make_item(ACT_WRITE, -2, 0));
        send_item(make_item(ACT_WRITE, 1, 0));
        send_item(make_item(ACT_READ, 0, 64));

        // count above the ring saturates to all blocks
        setup_ring(2, 15);
        for (int i = 0; i < 17; i++)
            send_item(make_item(ACT_WRITE, i * 1000 - 8000, 0));
        send_item(make_item(ACT_READ, 0, 65));

        for (int p = 0; p < 6; p++)
            random_phase(phase_size[p], phase_count[p], phase_idle[p], 14, p == 1);

        // largest blocks: a few writes leave no complete block, so reads pad
        setup_ring(511, 2);
        for (int i = 0; i < 6; i++)
            send_item(random_item(RING_ATOM, 100));
        for (int i = 0; i < 3; i++)
        begin
            sender_gap(7);
            send_item(make_item(ACT_READ, $urandom_range(0, 65535), RING_READ));
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (sb.faults == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
